/* hw/rtl/fcst_pkg.sv */
package fcst_pkg;

   // Field and port widths.
   localparam int FRAME_W    = 31;
   localparam int WORD_W     = 31;
   localparam int RATE_W     = 6;
   localparam int ERR_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Error codes, in the priority order in which they are checked.
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE             = 2'd0,
      ERR_RATE_UNSPEC      = 2'd1,
      ERR_DROP_RATE        = 2'd2,
      ERR_RATE_UNSUPPORTED = 2'd3
   } error_code_type;

   // Register indexes, decoded from the word address.
   typedef enum logic {
      CSR_FRAME_RATE = 1'b0,
      CSR_DROP_FRAME = 1'b1
   } csr_index_type;

   // Supported rounded frame rates.
   localparam logic [RATE_W-1:0] RATE_NONE  = 6'd0;
   localparam logic [RATE_W-1:0] RATE_24    = 6'd24;
   localparam logic [RATE_W-1:0] RATE_25    = 6'd25;
   localparam logic [RATE_W-1:0] RATE_30    = 6'd30;
   localparam logic [RATE_W-1:0] RESET_RATE = RATE_30;

   // Drop-frame renumbering constants.
   localparam logic [14:0] DF_BLOCK     = 15'd17982;
   localparam logic [10:0] DF_SUB       = 11'd1798;
   localparam logic [4:0]  DF_BLOCK_ADD = 5'd18;
   localparam logic [1:0]  DF_SUB_SKIP  = 2'd2;
   localparam int          DF_SUB_MAX   = 9;

   // Intermediate value widths.
   localparam int BLOCK_Q_W = 17;
   localparam int REST_W    = 15;
   localparam int EXTRA_W   = 4;
   localparam int RENUM_W   = 32;
   localparam int SEC_W     = 27;
   localparam int MIN_W     = 21;
   localparam int HOUR_W    = 15;
   localparam int DAY_W     = 11;

   // Reciprocals for exact division by constants: q = (x * ceil(2^k / d)) >> k.
   localparam int DF_SHIFT  = 46;
   localparam int DF_RCP_W  = 32;
   localparam logic [DF_RCP_W-1:0] DF_RCP =
      DF_RCP_W'(((64'd1 << DF_SHIFT) + 64'(DF_BLOCK) - 64'd1) / 64'(DF_BLOCK));

   localparam int FPS_SHIFT = 37;
   localparam int FPS_RCP_W = 33;
   localparam logic [FPS_RCP_W-1:0] RCP_24 =
      FPS_RCP_W'(((64'd1 << FPS_SHIFT) + 64'd23) / 64'd24);
   localparam logic [FPS_RCP_W-1:0] RCP_25 =
      FPS_RCP_W'(((64'd1 << FPS_SHIFT) + 64'd24) / 64'd25);
   localparam logic [FPS_RCP_W-1:0] RCP_30 =
      FPS_RCP_W'(((64'd1 << FPS_SHIFT) + 64'd29) / 64'd30);

   localparam int SEC60_SHIFT = 33;
   localparam int SEC60_RCP_W = 28;
   localparam logic [SEC60_RCP_W-1:0] SEC60_RCP =
      SEC60_RCP_W'(((64'd1 << SEC60_SHIFT) + 64'd59) / 64'd60);

   localparam int MIN60_SHIFT = 27;
   localparam int MIN60_RCP_W = 22;
   localparam logic [MIN60_RCP_W-1:0] MIN60_RCP =
      MIN60_RCP_W'(((64'd1 << MIN60_SHIFT) + 64'd59) / 64'd60);

   localparam int HOUR24_SHIFT = 20;
   localparam int HOUR24_RCP_W = 16;
   localparam logic [HOUR24_RCP_W-1:0] HOUR24_RCP =
      HOUR24_RCP_W'(((64'd1 << HOUR24_SHIFT) + 64'd23) / 64'd24);

   // Two-digit BCD of a value below 60, by a compare ladder for the tens digit.
   function automatic logic [7:0] bcd2(input logic [5:0] v);
      logic [3:0] tens;
      logic [5:0] units;
      if (v >= 6'd50) begin
         tens = 4'd5;
      end else if (v >= 6'd40) begin
         tens = 4'd4;
      end else if (v >= 6'd30) begin
         tens = 4'd3;
      end else if (v >= 6'd20) begin
         tens = 4'd2;
      end else if (v >= 6'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      units = v - 6'(tens) * 6'd10;
      return {tens, units[3:0]};
   endfunction

endpackage

/* hw/rtl/fcst_req_if.sv */
interface fcst_req_if;
   logic                          valid;
   logic                          ready;
   logic [fcst_pkg::FRAME_W-1:0]  frame_number;

   modport source (output valid, output frame_number, input ready);
   modport sink   (input valid, input frame_number, output ready);
endinterface

/* hw/rtl/fcst_rsp_if.sv */
interface fcst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fcst_pkg::WORD_W-1:0]  timecode_word;
   logic [fcst_pkg::ERR_W-1:0]   error_code;

   modport source (output valid, output timecode_word, output error_code, input ready);
   modport sink   (input valid, input timecode_word, input error_code, output ready);
endinterface

/* hw/rtl/frame_count_to_smpte_timecode_unit.sv */
// Converts a frame count into a packed SMPTE BCD timecode word (hours mod 24, bit 30 the
// drop flag), with 29.97 drop-frame renumbering when drop_frame is set. Each word passes
// through an eleven-stage pipeline, one exact reciprocal multiply or one small correction
// per stage; a frame count enters the first stage at the edge that takes it, and a new word
// is accepted in every cycle unless the pipeline is full behind a stalled result. Each stage
// holds its word on its own when the result side stalls, so empty stages still fill while a
// finished result waits. The rate and drop registers sit at byte addresses 0 and 4 of the
// APB port; change them only while no word is in flight. A bad rate setting gives a zero
// word and a nonzero error code.
module frame_count_to_smpte_timecode_unit (
   input  logic                              clock,
   input  logic                              reset,
   fcst_req_if.sink                          req_port,
   fcst_rsp_if.source                        rsp_port,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcst_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fcst_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fcst_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int NUM_STAGES = 11;

   // Configuration registers.
   logic [fcst_pkg::RATE_W-1:0] rate_ff;
   logic                        drop_ff;
   logic                        csr_write;
   fcst_pkg::csr_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = fcst_pkg::csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= fcst_pkg::RESET_RATE;
         drop_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            fcst_pkg::CSR_FRAME_RATE: rate_ff <= csr_pwdata[fcst_pkg::RATE_W-1:0];
            fcst_pkg::CSR_DROP_FRAME: drop_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fcst_pkg::CSR_FRAME_RATE:
            csr_prdata = {{(fcst_pkg::CSR_DATA_W-fcst_pkg::RATE_W){1'b0}}, rate_ff};
         fcst_pkg::CSR_DROP_FRAME:
            csr_prdata = {{(fcst_pkg::CSR_DATA_W-1){1'b0}}, drop_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Rate check, first error found wins.
   fcst_pkg::error_code_type err_now;

   always_comb begin
      if (rate_ff == fcst_pkg::RATE_NONE) begin
         err_now = fcst_pkg::ERR_RATE_UNSPEC;
      end else if (drop_ff && rate_ff != fcst_pkg::RATE_30) begin
         err_now = fcst_pkg::ERR_DROP_RATE;
      end else if (rate_ff != fcst_pkg::RATE_24 && rate_ff != fcst_pkg::RATE_25 &&
                   rate_ff != fcst_pkg::RATE_30) begin
         err_now = fcst_pkg::ERR_RATE_UNSUPPORTED;
      end else begin
         err_now = fcst_pkg::ERR_NONE;
      end
   end

   // Pipeline flow control: a stage loads when it is empty or its successor loads.
   logic [NUM_STAGES-1:0] vld_src;
   logic [NUM_STAGES:1]   vld_ff;
   logic [NUM_STAGES+1:1] adv;

   assign vld_src[0]              = req_port.valid;
   assign vld_src[NUM_STAGES-1:1] = vld_ff[NUM_STAGES-1:1];
   assign adv[NUM_STAGES+1]       = rsp_port.ready;
   assign req_port.ready          = adv[1];

   for (genvar i = 1; i <= NUM_STAGES; i++) begin : g_flow
      assign adv[i] = !vld_ff[i] || adv[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            vld_ff[i] <= vld_src[i-1];
         end
      end
   end

   // Stage 1: multiply by the reciprocal of the 17982-frame block.
   logic [fcst_pkg::FRAME_W-1:0]                      n1_ff;
   logic [fcst_pkg::BLOCK_Q_W-1:0]                    q1_ff;
   logic [fcst_pkg::FRAME_W+fcst_pkg::DF_RCP_W-1:0]   prod1;

   assign prod1 = (fcst_pkg::FRAME_W+fcst_pkg::DF_RCP_W)'(req_port.frame_number) *
                  (fcst_pkg::FRAME_W+fcst_pkg::DF_RCP_W)'(fcst_pkg::DF_RCP);

   // Stage 2: block remainder, and in drop-frame mode the count with 18 frames added per whole block.
   logic [fcst_pkg::REST_W-1:0]  rest2_ff;
   logic [fcst_pkg::RENUM_W-1:0] base2_ff;
   logic [fcst_pkg::FRAME_W-1:0] rest2_full;
   logic [fcst_pkg::RENUM_W-1:0] base2;

   always_comb begin
      rest2_full = n1_ff - fcst_pkg::FRAME_W'(q1_ff) * fcst_pkg::FRAME_W'(fcst_pkg::DF_BLOCK);
      if (drop_ff) begin
         base2 = fcst_pkg::RENUM_W'(n1_ff) +
                 fcst_pkg::RENUM_W'(q1_ff) * fcst_pkg::RENUM_W'(fcst_pkg::DF_BLOCK_ADD);
      end else begin
         base2 = fcst_pkg::RENUM_W'(n1_ff);
      end
   end

   // Stage 3: in drop-frame mode, 2 frames per whole 1798 of the remainder less 2, by threshold compares.
   logic [fcst_pkg::RENUM_W-1:0] n3_ff;
   logic [fcst_pkg::EXTRA_W-1:0] extra3;

   always_comb begin
      extra3 = '0;
      for (int k = 1; k <= fcst_pkg::DF_SUB_MAX; k++) begin
         if (rest2_ff >= fcst_pkg::REST_W'(fcst_pkg::DF_SUB_SKIP) +
                         fcst_pkg::REST_W'(k) * fcst_pkg::REST_W'(fcst_pkg::DF_SUB)) begin
            extra3 = extra3 + 1'b1;
         end
      end
      if (!drop_ff) begin
         extra3 = '0;
      end
   end

   // Stage 4: multiply by the reciprocal of the frame rate.
   logic [fcst_pkg::RENUM_W-1:0]                        n4_ff;
   logic [fcst_pkg::SEC_W-1:0]                          s4_ff;
   logic [fcst_pkg::FPS_RCP_W-1:0]                      fps_rcp;
   logic [fcst_pkg::RENUM_W+fcst_pkg::FPS_RCP_W-1:0]    prod4;

   always_comb begin
      case (rate_ff)
         fcst_pkg::RATE_24: fps_rcp = fcst_pkg::RCP_24;
         fcst_pkg::RATE_25: fps_rcp = fcst_pkg::RCP_25;
         default:           fps_rcp = fcst_pkg::RCP_30;
      endcase
      prod4 = (fcst_pkg::RENUM_W+fcst_pkg::FPS_RCP_W)'(n3_ff) *
              (fcst_pkg::RENUM_W+fcst_pkg::FPS_RCP_W)'(fps_rcp);
   end

   // Stage 5: frames within the second.
   logic [fcst_pkg::SEC_W-1:0] s5_ff;
   logic [4:0]                 ff5_ff;
   logic [fcst_pkg::RENUM_W-1:0] ff5_full;

   assign ff5_full = n4_ff - fcst_pkg::RENUM_W'(s4_ff) * fcst_pkg::RENUM_W'(rate_ff);

   // Stage 6: multiply seconds by the reciprocal of 60.
   logic [fcst_pkg::SEC_W-1:0]                           s6_ff;
   logic [fcst_pkg::MIN_W-1:0]                           m6_ff;
   logic [4:0]                                           ff6_ff;
   logic [fcst_pkg::SEC_W+fcst_pkg::SEC60_RCP_W-1:0]     prod6;

   assign prod6 = (fcst_pkg::SEC_W+fcst_pkg::SEC60_RCP_W)'(s5_ff) *
                  (fcst_pkg::SEC_W+fcst_pkg::SEC60_RCP_W)'(fcst_pkg::SEC60_RCP);

   // Stage 7: seconds within the minute.
   logic [fcst_pkg::MIN_W-1:0] m7_ff;
   logic [5:0]                 ss7_ff;
   logic [4:0]                 ff7_ff;
   logic [fcst_pkg::SEC_W-1:0] ss7_full;

   assign ss7_full = s6_ff - fcst_pkg::SEC_W'(m6_ff) * fcst_pkg::SEC_W'(60);

   // Stage 8: multiply minutes by the reciprocal of 60.
   logic [fcst_pkg::MIN_W-1:0]                           m8_ff;
   logic [fcst_pkg::HOUR_W-1:0]                          h8_ff;
   logic [5:0]                                           ss8_ff;
   logic [4:0]                                           ff8_ff;
   logic [fcst_pkg::MIN_W+fcst_pkg::MIN60_RCP_W-1:0]     prod8;

   assign prod8 = (fcst_pkg::MIN_W+fcst_pkg::MIN60_RCP_W)'(m7_ff) *
                  (fcst_pkg::MIN_W+fcst_pkg::MIN60_RCP_W)'(fcst_pkg::MIN60_RCP);

   // Stage 9: minutes within the hour.
   logic [fcst_pkg::HOUR_W-1:0] h9_ff;
   logic [5:0]                  mm9_ff;
   logic [5:0]                  ss9_ff;
   logic [4:0]                  ff9_ff;
   logic [fcst_pkg::MIN_W-1:0]  mm9_full;

   assign mm9_full = m8_ff - fcst_pkg::MIN_W'(h8_ff) * fcst_pkg::MIN_W'(60);

   // Stage 10: multiply hours by the reciprocal of 24.
   logic [fcst_pkg::HOUR_W-1:0]                            h10_ff;
   logic [fcst_pkg::DAY_W-1:0]                             d10_ff;
   logic [5:0]                                             mm10_ff;
   logic [5:0]                                             ss10_ff;
   logic [4:0]                                             ff10_ff;
   logic [fcst_pkg::HOUR_W+fcst_pkg::HOUR24_RCP_W-1:0]     prod10;

   assign prod10 = (fcst_pkg::HOUR_W+fcst_pkg::HOUR24_RCP_W)'(h9_ff) *
                   (fcst_pkg::HOUR_W+fcst_pkg::HOUR24_RCP_W)'(fcst_pkg::HOUR24_RCP);

   // Stage 11: hours mod 24, BCD packing and the error check into the output register.
   logic [fcst_pkg::WORD_W-1:0] word11_ff;
   logic [fcst_pkg::ERR_W-1:0]  err11_ff;
   logic [fcst_pkg::HOUR_W-1:0] hh11_full;
   logic [31:0]                 word11;

   always_comb begin
      hh11_full = h10_ff - fcst_pkg::HOUR_W'(d10_ff) * fcst_pkg::HOUR_W'(24);
      word11 = {1'b0, drop_ff, 30'd0}
             | {fcst_pkg::bcd2({1'b0, ff10_ff}), 24'd0}
             | {8'd0, fcst_pkg::bcd2(ss10_ff), 16'd0}
             | {16'd0, fcst_pkg::bcd2(mm10_ff), 8'd0}
             | {24'd0, fcst_pkg::bcd2(hh11_full[5:0])};
      if (err_now != fcst_pkg::ERR_NONE) begin
         word11 = '0;
      end
   end

   // Payload registers, each loaded when its stage advances.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         n1_ff <= req_port.frame_number;
         q1_ff <= prod1[fcst_pkg::DF_SHIFT +: fcst_pkg::BLOCK_Q_W];
      end
      if (adv[2]) begin
         rest2_ff <= rest2_full[fcst_pkg::REST_W-1:0];
         base2_ff <= base2;
      end
      if (adv[3]) begin
         n3_ff <= base2_ff + fcst_pkg::RENUM_W'({extra3, 1'b0});
      end
      if (adv[4]) begin
         n4_ff <= n3_ff;
         s4_ff <= prod4[fcst_pkg::FPS_SHIFT +: fcst_pkg::SEC_W];
      end
      if (adv[5]) begin
         s5_ff  <= s4_ff;
         ff5_ff <= ff5_full[4:0];
      end
      if (adv[6]) begin
         s6_ff  <= s5_ff;
         m6_ff  <= prod6[fcst_pkg::SEC60_SHIFT +: fcst_pkg::MIN_W];
         ff6_ff <= ff5_ff;
      end
      if (adv[7]) begin
         m7_ff  <= m6_ff;
         ss7_ff <= ss7_full[5:0];
         ff7_ff <= ff6_ff;
      end
      if (adv[8]) begin
         m8_ff  <= m7_ff;
         h8_ff  <= prod8[fcst_pkg::MIN60_SHIFT +: fcst_pkg::HOUR_W];
         ss8_ff <= ss7_ff;
         ff8_ff <= ff7_ff;
      end
      if (adv[9]) begin
         h9_ff  <= h8_ff;
         mm9_ff <= mm9_full[5:0];
         ss9_ff <= ss8_ff;
         ff9_ff <= ff8_ff;
      end
      if (adv[10]) begin
         h10_ff  <= h9_ff;
         d10_ff  <= prod10[fcst_pkg::HOUR24_SHIFT +: fcst_pkg::DAY_W];
         mm10_ff <= mm9_ff;
         ss10_ff <= ss9_ff;
         ff10_ff <= ff9_ff;
      end
      if (adv[11]) begin
         word11_ff <= word11[fcst_pkg::WORD_W-1:0];
         err11_ff  <= err_now;
      end
   end

   assign rsp_port.valid         = vld_ff[NUM_STAGES];
   assign rsp_port.timecode_word = word11_ff;
   assign rsp_port.error_code    = err11_ff;

endmodule

/* hw/rtl/fcst_checker.sv */
module fcst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fcst_pkg::WORD_W-1:0]    rsp_timecode_word,
   input logic [fcst_pkg::ERR_W-1:0]     rsp_error_code
);

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // The input side only stalls when the whole pipeline is full behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the result side can move");

   // An error result carries a zero timecode word.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != fcst_pkg::ERR_NONE) |-> (rsp_timecode_word == '0))
      else $error("error result with a nonzero timecode word");

   // A good result holds legal BCD digits.
   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == fcst_pkg::ERR_NONE) |->
         (rsp_timecode_word[27:24] <= 4'd9 && rsp_timecode_word[19:16] <= 4'd9 &&
          rsp_timecode_word[11:8] <= 4'd9 && rsp_timecode_word[3:0] <= 4'd9 &&
          rsp_timecode_word[22:20] <= 3'd5 && rsp_timecode_word[14:12] <= 3'd5))
      else $error("timecode word holds an illegal BCD digit");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_timecode_word) && $stable(rsp_error_code)))
      else $error("stalled result word changed");

endmodule

bind frame_count_to_smpte_timecode_unit fcst_checker u_fcst_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_timecode_word (rsp_port.timecode_word),
   .rsp_error_code    (rsp_port.error_code)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   // Drop-frame renumbering and clock arithmetic.
   localparam longint unsigned DROP_SPAN      = 17982;
   localparam longint unsigned DROP_MINUTE    = 1798;
   localparam longint unsigned DROP_SPAN_ADD  = 18;
   localparam longint unsigned DROP_SKIP      = 2;
   localparam longint unsigned SECS_PER_MIN   = 60;
   localparam longint unsigned SECS_PER_HOUR  = 3600;
   localparam longint unsigned HOURS_PER_DAY  = 24;

   localparam int PIPE_LATENCY    = 11;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 180;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic [fcst_pkg::WORD_W-1:0] timecode_word;
      fcst_pkg::error_code_type    error_code;
   } timecode_type;

   typedef struct {
      logic [fcst_pkg::RATE_W-1:0]  rate;
      logic                         drop;
      logic [fcst_pkg::FRAME_W-1:0] frames;
      bit                           typed;
      timecode_type                 result;
   } stimulus_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [fcst_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [fcst_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [fcst_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   fcst_req_if req_bus ();
   fcst_rsp_if rsp_bus ();

   frame_count_to_smpte_timecode_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register settings as the block should hold them.
   logic [fcst_pkg::RATE_W-1:0] rate_setting = fcst_pkg::RESET_RATE;
   logic                        drop_setting = 1'b0;

   timecode_type pending_timecodes [$];
   int           failures;
   int           words_sent;
   int           words_checked;
   int           settings_applied;
   int           cycle_count;
   bit           steady;

   // Directed words: known values are typed in, the rest go through the predictor.
   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{6'd30, 1'b0, 31'd0,        1'b1, '{31'h00000000, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b0, 31'd1,        1'b1, '{31'h01000000, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b0, 31'd29,       1'b1, '{31'h29000000, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b0, 31'd30,       1'b1, '{31'h00010000, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b0, 31'd1799,     1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b0, 31'h7FFFFFFF, 1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd24, 1'b0, 31'd0,        1'b1, '{31'h00000000, fcst_pkg::ERR_NONE}},
      '{6'd24, 1'b0, 31'd2073599,  1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd24, 1'b0, 31'd2073600,  1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd25, 1'b0, 31'h55555555, 1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd25, 1'b0, 31'h2AAAAAAA, 1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd0,        1'b1, '{31'h40000000, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd1799,     1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd1800,     1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd17981,    1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd17982,    1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd17983,    1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'd17984,    1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd30, 1'b1, 31'h7FFFFFFF, 1'b0, '{31'h0, fcst_pkg::ERR_NONE}},
      '{6'd0,  1'b0, 31'h7FFFFFFF, 1'b1, '{31'h0, fcst_pkg::ERR_RATE_UNSPEC}},
      '{6'd0,  1'b1, 31'd123,      1'b1, '{31'h0, fcst_pkg::ERR_RATE_UNSPEC}},
      '{6'd24, 1'b1, 31'd5,        1'b1, '{31'h0, fcst_pkg::ERR_DROP_RATE}},
      '{6'd63, 1'b1, 31'd5,        1'b1, '{31'h0, fcst_pkg::ERR_DROP_RATE}},
      '{6'd63, 1'b0, 31'd1000,     1'b1, '{31'h0, fcst_pkg::ERR_RATE_UNSUPPORTED}},
      '{6'd1,  1'b0, 31'd0,        1'b1, '{31'h0, fcst_pkg::ERR_RATE_UNSUPPORTED}}
   };

   // Two BCD digits of a value below 100.
   function automatic logic [7:0] to_bcd(input longint unsigned value);
      return {4'(value / 10), 4'(value % 10)};
   endfunction

   // Expected timecode word and error code for one frame count.
   function automatic timecode_type smpte_timecode(
         input logic [fcst_pkg::FRAME_W-1:0] frames,
         input logic [fcst_pkg::RATE_W-1:0] rate,
         input logic drop);
      longint unsigned count;
      longint unsigned fps;
      longint unsigned rest;
      longint unsigned extra;
      logic [31:0]     packed_word;
      timecode_type    tc;
      tc.timecode_word = '0;
      if (rate == fcst_pkg::RATE_NONE) begin
         tc.error_code = fcst_pkg::ERR_RATE_UNSPEC;
      end else if (drop && rate != fcst_pkg::RATE_30) begin
         tc.error_code = fcst_pkg::ERR_DROP_RATE;
      end else if (rate != fcst_pkg::RATE_24 && rate != fcst_pkg::RATE_25 &&
                   rate != fcst_pkg::RATE_30) begin
         tc.error_code = fcst_pkg::ERR_RATE_UNSUPPORTED;
      end else begin
         tc.error_code = fcst_pkg::ERR_NONE;
         count = frames;
         fps = rate;
         // Skip the dropped frame numbers at full width before any wrap.
         if (drop) begin
            rest = count % DROP_SPAN;
            extra = (rest < DROP_SKIP) ? 0 : (rest - DROP_SKIP) / DROP_MINUTE;
            count = count + DROP_SPAN_ADD * (count / DROP_SPAN) + DROP_SKIP * extra;
         end
         packed_word = (32'(drop) << 30)
                     | (32'(to_bcd(count % fps)) << 24)
                     | (32'(to_bcd((count / fps) % SECS_PER_MIN)) << 16)
                     | (32'(to_bcd((count / (fps * SECS_PER_MIN)) % SECS_PER_MIN)) << 8)
                     | 32'(to_bcd((count / (fps * SECS_PER_HOUR)) % HOURS_PER_DAY));
         tc.timecode_word = packed_word[fcst_pkg::WORD_W-1:0];
      end
      return tc;
   endfunction

   // Clock and cycle count.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $error("Timeout after %0d cycles with %0d words outstanding",
             cycle_count, pending_timecodes.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: check each accepted word against the oldest expectation.
   always @(posedge clock) begin
      timecode_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_timecodes.size() == 0) begin
               $error("Unexpected word: timecode_word %h error_code %0d",
                      rsp_bus.timecode_word, rsp_bus.error_code);
               failures++;
            end else begin
               due = pending_timecodes.pop_front();
               if (rsp_bus.timecode_word !== due.timecode_word) begin
                  $error("timecode_word: expected %h, actual %h",
                         due.timecode_word, rsp_bus.timecode_word);
                  failures++;
               end
               if (rsp_bus.error_code !== due.error_code) begin
                  $error("error_code: expected %0d, actual %0d",
                         due.error_code, rsp_bus.error_code);
                  failures++;
               end
               words_checked++;
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 29);
      end
   end

   // One APB write; psel stays high so that writes can follow back to back.
   task automatic write_register(input fcst_pkg::csr_index_type reg_index,
                                 input logic [fcst_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= fcst_pkg::CSR_ADDR_W'({reg_index, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_index == fcst_pkg::CSR_FRAME_RATE) begin
         rate_setting = data[fcst_pkg::RATE_W-1:0];
      end else begin
         drop_setting = data[0];
      end
   endtask

   // Hold the sender off until every expected word has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_timecodes.size() != 0);
   endtask

   // Change both registers once the pipeline is empty; noisy writes set upper bits.
   task automatic apply_settings(input logic [fcst_pkg::RATE_W-1:0] rate, input logic drop,
                                 input bit noisy);
      logic [fcst_pkg::CSR_DATA_W-1:0] upper;
      drain_results();
      upper = noisy ? fcst_pkg::CSR_DATA_W'($urandom) : '0;
      write_register(fcst_pkg::CSR_FRAME_RATE,
                     {upper[fcst_pkg::CSR_DATA_W-1:fcst_pkg::RATE_W], rate});
      upper = noisy ? fcst_pkg::CSR_DATA_W'($urandom) : '0;
      write_register(fcst_pkg::CSR_DROP_FRAME, {upper[fcst_pkg::CSR_DATA_W-1:1], drop});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_applied++;
   endtask

   // Offer one frame count, with random gaps, and record what it should give.
   task automatic send_frame_count(input logic [fcst_pkg::FRAME_W-1:0] frames,
                                   input bit typed,
                                   input timecode_type typed_result);
      while (!steady && $urandom_range(99) < 29) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.frame_number <= frames;
      do @(posedge clock); while (!req_bus.ready);
      pending_timecodes.push_back(typed ? typed_result
                                        : smpte_timecode(frames, rate_setting, drop_setting));
      words_sent++;
   endtask

   // Main sequence.
   initial begin
      logic [fcst_pkg::RATE_W-1:0]  rate;
      logic                         drop;
      logic [fcst_pkg::FRAME_W-1:0] frames;
      longint unsigned              base;
      int                           drain_at;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.frame_number <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, starting from the reset settings.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].rate != rate_setting || directed_rows[r].drop != drop_setting) begin
            apply_settings(directed_rows[r].rate, directed_rows[r].drop, 1'b0);
         end
         send_frame_count(directed_rows[r].frames, directed_rows[r].typed,
                          directed_rows[r].result);
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin rate = fcst_pkg::RATE_30; drop = 1'b1; end
            1: begin rate = fcst_pkg::RATE_24; drop = 1'b0; end
            2: begin rate = fcst_pkg::RATE_25; drop = 1'b0; end
            3: begin rate = 6'd63;   drop = 1'($urandom); end
            default: begin
               case ($urandom_range(7))
                  0, 1: begin rate = fcst_pkg::RATE_30; drop = 1'b1; end
                  2: begin rate = fcst_pkg::RATE_30; drop = 1'b0; end
                  3: begin rate = fcst_pkg::RATE_24; drop = 1'b0; end
                  4: begin rate = fcst_pkg::RATE_25; drop = 1'b0; end
                  5: begin rate = fcst_pkg::RATE_W'($urandom); drop = 1'($urandom); end
                  6: begin rate = fcst_pkg::RATE_NONE; drop = 1'($urandom); end
                  default: begin
                     rate = $urandom_range(1) ? fcst_pkg::RATE_24 : fcst_pkg::RATE_25;
                     drop = 1'b1;
                  end
               endcase
            end
         endcase
         // One phase runs with no idling on either side.
         steady = (phase == 1);
         apply_settings(rate, drop, 1'b1);
         drain_at = $urandom_range(ITEMS_PER_PHASE - 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == drain_at) begin
               drain_results();
            end
            case ($urandom_range(9))
               0, 1, 2, 3: frames = fcst_pkg::FRAME_W'($urandom_range(2600000));
               4, 5: begin
                  // Close to the edges of the drop-frame minute and ten-minute blocks.
                  base = longint'($urandom_range(119000)) * DROP_SPAN
                       + longint'($urandom_range(9)) * DROP_MINUTE
                       + longint'($urandom_range(3));
                  frames = fcst_pkg::FRAME_W'(base);
               end
               8: begin
                  case ($urandom_range(2))
                     0: frames = '0;
                     1: frames = '1;
                     default: frames = fcst_pkg::FRAME_W'(1) <<
                                       $urandom_range(fcst_pkg::FRAME_W - 1);
                  endcase
                  if ($urandom_range(3) == 0) begin
                     frames = ~frames;
                  end
               end
               default: frames = fcst_pkg::FRAME_W'($urandom);
            endcase
            send_frame_count(frames, 1'b0, '0);
         end
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      // Let the pipeline empty, then watch for stray words.
      while (pending_timecodes.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Checked %0d of %0d frame counts under %0d register settings,",
               words_checked, words_sent, settings_applied);
      $display("covering all three rates, drop-frame numbering and every error code.");
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* frame_count_to_smpte_timecode_unit.f */
hw/rtl/fcst_pkg.sv
hw/rtl/fcst_req_if.sv
hw/rtl/fcst_rsp_if.sv
hw/rtl/frame_count_to_smpte_timecode_unit.sv
hw/rtl/fcst_checker.sv
sim/testbench.sv
